@@ design/nmea_wind_sentence_parser_defines.svh @@
// Assertion macros shared by the wind sentence parser modules.
`ifndef NMEA_WIND_SENTENCE_PARSER_DEFINES_SVH
`define NMEA_WIND_SENTENCE_PARSER_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define NWSP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The condition must hold in the cycle after the trigger.
`define NWSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/nwsp_pkg.sv @@
// Shared types, constants and helpers for the wind sentence parser.
package nwsp_pkg;

  localparam int MAX_FIELDS     = 10;
  localparam int MIN_FIELDS     = 6;
  localparam int FN_W           = 4;
  localparam int PREFIX_LEN     = 6;
  localparam int FIFO_DEPTH     = 4;
  localparam int FIFO_AW        = 2;
  localparam int FIFO_CW        = 3;
  localparam int VAL_W          = 17;
  localparam int MAG_W          = 16;

  localparam logic [FN_W-1:0] FIELD_LAST   = FN_W'(MAX_FIELDS - 1);
  localparam logic [FN_W-1:0] FIELD_ENOUGH = FN_W'(MIN_FIELDS - 1);
  localparam logic [FN_W-1:0] FIELD_ANGLE  = FN_W'(1);
  localparam logic [FN_W-1:0] FIELD_REF    = FN_W'(2);
  localparam logic [FN_W-1:0] FIELD_SPEED  = FN_W'(3);
  localparam logic [FN_W-1:0] FIELD_UNIT   = FN_W'(4);
  localparam logic [FN_W-1:0] FIELD_STATUS = FN_W'(5);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [MAG_W-1:0] MAG_LIMIT = '1;

  typedef enum logic [2:0] {
    CLS_DIGIT = 3'd0,
    CLS_PLUS  = 3'd1,
    CLS_MINUS = 3'd2,
    CLS_DOT   = 3'd3,
    CLS_COMMA = 3'd4,
    CLS_STAR  = 3'd5,
    CLS_OTHER = 3'd6
  } char_class_t;

  typedef struct packed {
    logic [7:0]  ch;
    char_class_t cls;
    logic        eos;
    logic        prefix_good;
  } token_t;

  typedef struct packed {
    logic sign;
    logic dot;
    logic frac;
    logic stopped;
    logic roundup;
  } num_flags_t;

  function automatic logic [7:0] prefix_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h24; // '$'
      3'd1:    c = 8'h57; // 'W'
      3'd2:    c = 8'h49; // 'I'
      3'd3:    c = 8'h4D; // 'M'
      3'd4:    c = 8'h57; // 'W'
      3'd5:    c = 8'h56; // 'V'
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t k;
    if (c >= CH_ZERO && c <= CH_NINE) k = CLS_DIGIT;
    else if (c == CH_PLUS)            k = CLS_PLUS;
    else if (c == CH_MINUS)           k = CLS_MINUS;
    else if (c == CH_DOT)             k = CLS_DOT;
    else if (c == CH_COMMA)           k = CLS_COMMA;
    else if (c == CH_STAR)            k = CLS_STAR;
    else                              k = CLS_OTHER;
    return k;
  endfunction

endpackage

@@ design/nwsp_front.sv @@
// Front end: takes bytes, tracks the prefix and classifies each byte into a token.
module nwsp_front (
  input  logic            clk,
  input  logic            rst,
  input  logic [7:0]      char_in,
  input  logic            end_of_sentence,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            queue_full,
  output logic            push,
  output nwsp_pkg::token_t push_data
);
  import nwsp_pkg::*;

  logic [2:0] prefix_pos;
  logic       prefix_failed;
  logic [2:0] prefix_pos_next;
  logic       prefix_failed_next;
  logic       in_prefix;

  assign in_stall  = queue_full;
  assign push      = in_valid && !queue_full;
  assign in_prefix = prefix_pos < 3'(PREFIX_LEN);

  always_comb begin
    prefix_pos_next    = prefix_pos;
    prefix_failed_next = prefix_failed;
    if (in_prefix) begin
      prefix_pos_next = prefix_pos + 3'd1;
      if (char_in != prefix_char(prefix_pos)) prefix_failed_next = 1'b1;
    end
  end

  always_comb begin
    push_data.ch          = char_in;
    push_data.cls         = classify(char_in);
    push_data.eos         = end_of_sentence;
    push_data.prefix_good = !prefix_failed_next && prefix_pos_next >= 3'(PREFIX_LEN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_pos    <= '0;
      prefix_failed <= 1'b0;
    end else if (push) begin
      if (end_of_sentence) begin
        prefix_pos    <= '0;
        prefix_failed <= 1'b0;
      end else begin
        prefix_pos    <= prefix_pos_next;
        prefix_failed <= prefix_failed_next;
      end
    end
  end

endmodule

@@ design/nwsp_fifo.sv @@
// Short token queue between the front end and the field parser.
`include "nmea_wind_sentence_parser_defines.svh"

module nwsp_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  nwsp_pkg::token_t push_data,
  input  logic             pop,
  output nwsp_pkg::token_t pop_data,
  output logic             full,
  output logic             empty
);
  import nwsp_pkg::*;

  token_t             slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_CW-1:0] count;

  assign full     = count == FIFO_CW'(FIFO_DEPTH);
  assign empty    = count == '0;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + FIFO_AW'(1);
      if (pop)  rd_ptr <= rd_ptr + FIFO_AW'(1);
      case ({push, pop})
        2'b10:   count <= count + FIFO_CW'(1);
        2'b01:   count <= count - FIFO_CW'(1);
        default: count <= count;
      endcase
    end
  end

  `NWSP_ASSERT_SAME(a_no_pop_empty, pop, !empty, "token taken from an empty queue")
  `NWSP_ASSERT_SAME(a_no_push_full, push, !full, "token written into a full queue")
  `NWSP_ASSERT_SAME(a_count_bound, 1'b1, count <= FIFO_CW'(FIFO_DEPTH), "queue count overflow")

endmodule

@@ design/nwsp_back.sv @@
// Field parser: splits the token stream into fields and builds the result item.
`include "nmea_wind_sentence_parser_defines.svh"

module nwsp_back (
  input  logic                           clk,
  input  logic                           rst,
  input  nwsp_pkg::token_t               tok,
  input  logic                           tok_avail,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           sentence_valid,
  output logic signed [nwsp_pkg::VAL_W-1:0] wind_direction,
  output logic [7:0]                     angle_reference,
  output logic signed [nwsp_pkg::VAL_W-1:0] wind_speed,
  output logic [7:0]                     speed_unit,
  output logic [7:0]                     sensor_status
);
  import nwsp_pkg::*;

  logic [FN_W-1:0]  field_number, field_number_next;
  logic             after_star, after_star_next;
  logic [MAG_W-1:0] acc, acc_next;
  num_flags_t       flags, flags_next;
  logic             started, started_next;
  logic [VAL_W-1:0] saved_angle, saved_angle_next;
  logic [VAL_W-1:0] saved_speed, saved_speed_next;
  logic [7:0]       saved_ref, saved_ref_next;
  logic [7:0]       saved_unit, saved_unit_next;
  logic [7:0]       saved_status, saved_status_next;
  logic [19:0]      acc_times_ten;
  logic [VAL_W-1:0] rounded;
  logic [VAL_W-1:0] rounded_mag;
  logic [3:0]       digit;
  logic             result_good;
  logic             payload_zero;
  logic             state_clear;

  // A non-final token never blocks; the final one waits for the output register.
  assign pop = tok_avail && (!tok.eos || !out_valid || !out_stall);

  assign digit         = tok.ch[3:0];
  assign acc_times_ten = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {16'd0, digit};

  always_comb begin
    rounded_mag = {1'b0, acc};
    if (flags.roundup && acc != MAG_LIMIT) rounded_mag = rounded_mag + VAL_W'(1);
    rounded = flags.sign ? (~rounded_mag + VAL_W'(1)) : rounded_mag;
  end

  always_comb begin
    field_number_next = field_number;
    after_star_next   = after_star;
    acc_next          = acc;
    flags_next        = flags;
    started_next      = started;
    saved_angle_next  = saved_angle;
    saved_speed_next  = saved_speed;
    saved_ref_next    = saved_ref;
    saved_unit_next   = saved_unit;
    saved_status_next = saved_status;
    if (!after_star) begin
      case (tok.cls)
        CLS_STAR: begin
          after_star_next = 1'b1;
        end
        CLS_COMMA: begin
          if (field_number == FIELD_ANGLE) saved_angle_next = rounded;
          else if (field_number == FIELD_SPEED) saved_speed_next = rounded;
          if (field_number < FIELD_LAST) field_number_next = field_number + FN_W'(1);
          acc_next     = '0;
          flags_next   = '0;
          started_next = 1'b0;
        end
        default: begin
          if (field_number == FIELD_ANGLE || field_number == FIELD_SPEED) begin
            if (!flags.stopped) begin
              if (tok.cls inside {CLS_PLUS, CLS_MINUS} && !started) begin
                // A sign counts only as the very first byte of the field.
                flags_next.sign = tok.cls == CLS_MINUS;
                started_next    = 1'b1;
              end else begin
                started_next = 1'b1;
                case (tok.cls)
                  CLS_DIGIT: begin
                    if (!flags.dot) begin
                      acc_next = (acc_times_ten > {4'd0, MAG_LIMIT}) ? MAG_LIMIT
                                                                     : acc_times_ten[MAG_W-1:0];
                    end else if (!flags.frac) begin
                      flags_next.frac    = 1'b1;
                      flags_next.roundup = digit >= 4'd5;
                    end
                  end
                  CLS_DOT: begin
                    if (!flags.dot) flags_next.dot = 1'b1;
                    else flags_next.stopped = 1'b1;
                  end
                  default: flags_next.stopped = 1'b1;
                endcase
              end
            end
          end else if (!started) begin
            if (field_number == FIELD_REF) begin
              saved_ref_next = tok.ch;
              started_next   = 1'b1;
            end else if (field_number == FIELD_UNIT) begin
              saved_unit_next = tok.ch;
              started_next    = 1'b1;
            end else if (field_number == FIELD_STATUS) begin
              saved_status_next = tok.ch;
              started_next      = 1'b1;
            end
          end
        end
      endcase
    end
  end

  assign result_good = tok.prefix_good && field_number_next >= FIELD_ENOUGH;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_number <= '0;
      after_star   <= 1'b0;
      acc          <= '0;
      flags        <= '0;
      started      <= 1'b0;
      saved_angle  <= '0;
      saved_speed  <= '0;
      saved_ref    <= CH_SPACE;
      saved_unit   <= CH_SPACE;
      saved_status <= CH_SPACE;
    end else if (pop) begin
      if (tok.eos) begin
        field_number <= '0;
        after_star   <= 1'b0;
        acc          <= '0;
        flags        <= '0;
        started      <= 1'b0;
        saved_angle  <= '0;
        saved_speed  <= '0;
        saved_ref    <= CH_SPACE;
        saved_unit   <= CH_SPACE;
        saved_status <= CH_SPACE;
      end else begin
        field_number <= field_number_next;
        after_star   <= after_star_next;
        acc          <= acc_next;
        flags        <= flags_next;
        started      <= started_next;
        saved_angle  <= saved_angle_next;
        saved_speed  <= saved_speed_next;
        saved_ref    <= saved_ref_next;
        saved_unit   <= saved_unit_next;
        saved_status <= saved_status_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && tok.eos) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && tok.eos) begin
      sentence_valid  <= result_good;
      wind_direction  <= result_good ? saved_angle_next : '0;
      angle_reference <= result_good ? saved_ref_next : 8'd0;
      wind_speed      <= result_good ? saved_speed_next : '0;
      speed_unit      <= result_good ? saved_unit_next : 8'd0;
      sensor_status   <= result_good ? saved_status_next : 8'd0;
    end
  end

  assign payload_zero = wind_direction == '0 && wind_speed == '0 && angle_reference == 8'd0 &&
                        speed_unit == 8'd0 && sensor_status == 8'd0;
  assign state_clear  = field_number == '0 && !after_star && !started && acc == '0;

  `NWSP_ASSERT_SAME(a_invalid_zero, out_valid && !sentence_valid, payload_zero, "invalid item")
  `NWSP_ASSERT_SAME(a_field_bound, 1'b1, field_number <= FIELD_LAST, "field counter beyond its limit")
  `NWSP_ASSERT_NEXT(a_eos_clears, pop && tok.eos, state_clear, "state not cleared after final byte")

endmodule

@@ design/nmea_wind_sentence_parser.sv @@
// Wind sentence parser: one sentence byte per item, one result item per sentence.
// Throughput: one byte per clock cycle, sustained while the output side takes results.
// With nothing else queued, the result item is registered on the edge that takes its final
//   byte out of the four-entry token queue.
// A waiting result blocks only the next final byte; with three more bytes the queue fills.
// Reset (rst, synchronous) empties the queue and returns the parser to the start of a sentence.
module nmea_wind_sentence_parser (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [7:0]                        char_in,
  input  logic                              end_of_sentence,
  input  logic                              in_valid,
  output logic                              in_stall,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              sentence_valid,
  output logic signed [nwsp_pkg::VAL_W-1:0] wind_direction,
  output logic [7:0]                        angle_reference,
  output logic signed [nwsp_pkg::VAL_W-1:0] wind_speed,
  output logic [7:0]                        speed_unit,
  output logic [7:0]                        sensor_status
);
  import nwsp_pkg::*;

  token_t push_data;
  token_t pop_data;
  logic   push;
  logic   pop;
  logic   full;
  logic   empty;

  nwsp_front u_front (
    .clk             (clk),
    .rst             (rst),
    .char_in         (char_in),
    .end_of_sentence (end_of_sentence),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .queue_full      (full),
    .push            (push),
    .push_data       (push_data)
  );

  nwsp_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (full),
    .empty     (empty)
  );

  nwsp_back u_back (
    .clk             (clk),
    .rst             (rst),
    .tok             (pop_data),
    .tok_avail       (!empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .sentence_valid  (sentence_valid),
    .wind_direction  (wind_direction),
    .angle_reference (angle_reference),
    .wind_speed      (wind_speed),
    .speed_unit      (speed_unit),
    .sensor_status   (sensor_status)
  );

endmodule
